// ===== rtl/core/qrs_pkg.sv =====
// shared types, widths and codes for the quadratic root solver
package qrs_pkg;

  // coefficient and root formats
  localparam int IN_WIDTH     = 24;
  localparam int IN_FRAC_BITS = 12;
  localparam int OUT_WIDTH    = 32;

  // derived widths
  localparam int PROD_W   = 2 * IN_WIDTH;
  localparam int D_W      = 2 * IN_WIDTH + 1;
  localparam int SQ_STEPS = (D_W + 1) / 2;
  localparam int SQ_W     = SQ_STEPS;
  localparam int SQR_W    = SQ_W + 3;
  localparam int DP_W     = 2 * SQ_STEPS;
  localparam int NUM_W    = SQ_W + 2;
  localparam int NMAG_W   = NUM_W - 1;
  localparam int DIV_W    = NMAG_W + IN_FRAC_BITS;
  localparam int DEN_W    = IN_WIDTH + 1;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;

  typedef enum logic [1:0] {
    KIND_REAL    = 2'd0,
    KIND_COMPLEX = 2'd1,
    KIND_DOUBLE  = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] coef_a;
    logic signed [IN_WIDTH-1:0] coef_b;
    logic signed [IN_WIDTH-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic [1:0]                  root_kind;
    logic signed [OUT_WIDTH-1:0] first_value;
    logic signed [OUT_WIDTH-1:0] second_value;
    logic                        saturated;
  } out_t;

  // classified item passed from front to back
  typedef struct packed {
    kind_t                      kind;
    logic signed [IN_WIDTH-1:0] b;
    logic                       a_neg;
    logic [DEN_W-1:0]           den;
    logic [D_W-1:0]             dmag;
  } cls_t;

endpackage

// ===== rtl/core/quadratic_root_solver.sv =====
// top level of the quadratic root solver
// Usage:
//   in_valid/in_ready/in_data carry one equation (coef_a, coef_b, coef_c,
//   signed Q12.12) per transfer; out_valid/out_ready/out_data carry one
//   result (root_kind, first_value, second_value in Q20.12, saturated).
//   Throughput is one equation per cycle while out_ready stays high.
//   The path runs through two front stages, the queue, the back input
//   register, one back stage per root bit (25), one numerator stage,
//   one stage per quotient bit (38) and the output register.
//   The back pipeline is a single chain that advances only when the output
//   register is free; when the receiver stalls the back halts, the
//   four-entry queue fills, then the front stalls and in_ready drops.
//   A zero coef_a gives root_kind invalid with all values zero.
//   Reset (rst_n low, synchronous) empties the pipes and the queue;
//   no item is held across reset.
module quadratic_root_solver (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  qrs_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output qrs_pkg::out_t out_data
);
  import qrs_pkg::*;

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  cls_t fq_data, qb_data;

  qrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  qrs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  qrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (qb_valid),
    .in_ready  (qb_ready),
    .in_data   (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // invalid equations report all values cleared
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.root_kind == KIND_INVALID) |->
      (out_data.first_value == '0) && (out_data.second_value == '0) && !out_data.saturated)
    else $error("invalid result carries nonzero values");

  // a double root is repeated
  a_double_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.root_kind == KIND_DOUBLE) |->
      (out_data.second_value == out_data.first_value))
    else $error("double root values differ");

  // imaginary part is a magnitude
  a_imag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.root_kind == KIND_COMPLEX) |-> !out_data.second_value[OUT_WIDTH-1])
    else $error("negative imaginary magnitude");
`endif

endmodule

// ===== rtl/core/qrs_front.sv =====
// front end: accepts coefficients, forms products, classifies the discriminant
module qrs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qrs_pkg::in_t  in_data,
  output logic          q_valid,
  input  logic          q_ready,
  output qrs_pkg::cls_t q_data
);
  import qrs_pkg::*;

  logic                       v0_r, v1_r;
  in_t                        d0_r;
  logic [PROD_W-1:0]          bb_r, ac_r;
  logic                       a_neg_r, c_neg_r, a_zero_r, c_zero_r;
  logic [IN_WIDTH-1:0]        am_r;
  logic signed [IN_WIDTH-1:0] b_r;
  logic                       rdy1;
  logic [IN_WIDTH-1:0]        am, bm, cm;
  logic [D_W-1:0]             bb_e, ac4;

  // magnitude of a signed coefficient, the most negative value included
  function automatic logic [IN_WIDTH-1:0] mag(input logic [IN_WIDTH-1:0] x);
    mag = x[IN_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

  assign rdy1     = !v1_r || q_ready;
  assign in_ready = !v0_r || rdy1;

  assign am = mag(d0_r.coef_a);
  assign bm = mag(d0_r.coef_b);
  assign cm = mag(d0_r.coef_c);

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (in_ready) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
    end
  end

  // input register and product stage
  always_ff @(posedge clk) begin
    if (in_ready) d0_r <= in_data;
    if (rdy1) begin
      bb_r     <= PROD_W'(bm) * PROD_W'(bm);
      ac_r     <= PROD_W'(am) * PROD_W'(cm);
      a_neg_r  <= d0_r.coef_a[IN_WIDTH-1];
      c_neg_r  <= d0_r.coef_c[IN_WIDTH-1];
      a_zero_r <= (d0_r.coef_a == '0);
      c_zero_r <= (d0_r.coef_c == '0);
      am_r     <= am;
      b_r      <= d0_r.coef_b;
    end
  end

  // discriminant sign and magnitude
  assign bb_e = D_W'(bb_r);
  assign ac4  = D_W'(ac_r) << 2;

  always_comb begin
    q_data.b     = b_r;
    q_data.a_neg = a_neg_r;
    q_data.den   = {am_r, 1'b0};
    if (a_zero_r) begin
      q_data.kind = KIND_INVALID;
      q_data.dmag = '0;
    end else if (!c_zero_r && (a_neg_r != c_neg_r)) begin
      q_data.kind = KIND_REAL;
      q_data.dmag = bb_e + ac4;
    end else if (bb_e == ac4) begin
      q_data.kind = KIND_DOUBLE;
      q_data.dmag = '0;
    end else if (bb_e > ac4) begin
      q_data.kind = KIND_REAL;
      q_data.dmag = bb_e - ac4;
    end else begin
      q_data.kind = KIND_COMPLEX;
      q_data.dmag = ac4 - bb_e;
    end
  end

  assign q_valid = v1_r;

endmodule

// ===== rtl/core/qrs_fifo.sv =====
// short queue of classified items between front and back
module qrs_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  qrs_pkg::cls_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output qrs_pkg::cls_t pop_data
);
  import qrs_pkg::*;

  cls_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

// ===== rtl/core/qrs_back.sv =====
// back end: pipelined square root, two pipelined dividers, saturation
module qrs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qrs_pkg::cls_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qrs_pkg::out_t out_data
);
  import qrs_pkg::*;

  localparam int CMP_W = ((DIV_W > OUT_WIDTH) ? DIV_W : OUT_WIDTH) + 1;

  typedef struct packed {
    kind_t                      kind;
    logic signed [IN_WIDTH-1:0] b;
    logic                       a_neg;
    logic [DEN_W-1:0]           den;
    logic [DP_W-1:0]            d;
    logic [SQR_W-1:0]           rem;
    logic [SQ_W-1:0]            root;
  } sq_t;

  typedef struct packed {
    kind_t            kind;
    logic [DEN_W-1:0] den;
    logic             neg1;
    logic             neg2;
    logic [DIV_W-1:0] dq1;
    logic [DIV_W-1:0] dq2;
    logic [DEN_W-1:0] r1;
    logic [DEN_W-1:0] r2;
  } dv_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WIDTH-1:0] v;
  } sat_t;

  sq_t  sq_r   [SQ_STEPS+1];
  sq_t  sq_nxt [SQ_STEPS+1];
  logic sqv_r  [SQ_STEPS+1];
  dv_t  dv_r   [DIV_W+1];
  dv_t  dv_nxt [DIV_W+1];
  logic dvv_r  [DIV_W+1];
  logic out_valid_r;
  out_t out_r, out_nxt;
  logic en;

  // one bit of the root per stage
  function automatic sq_t sq_step(input sq_t s);
    sq_t              o;
    logic [SQR_W-1:0] t, trial;
    o     = s;
    t     = {s.rem[SQR_W-3:0], s.d[DP_W-1 -: 2]};
    trial = SQR_W'({s.root, 2'b01});
    o.d   = s.d << 2;
    if (t >= trial) begin
      o.rem  = t - trial;
      o.root = {s.root[SQ_W-2:0], 1'b1};
    end else begin
      o.rem  = t;
      o.root = {s.root[SQ_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit per stage, restoring
  function automatic logic [DEN_W+DIV_W-1:0] div_step(input logic [DIV_W-1:0] dq,
                                                     input logic [DEN_W-1:0] r,
                                                     input logic [DEN_W-1:0] den);
    logic [DEN_W:0]   t, diff;
    logic             ge;
    logic [DEN_W-1:0] rn;
    t    = {r, dq[DIV_W-1]};
    diff = t - {1'b0, den};
    ge   = (t >= {1'b0, den});
    rn   = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
    return {rn, dq[DIV_W-2:0], ge};
  endfunction

  // clamp a signed quotient to the output range
  function automatic sat_t clamp(input logic [DIV_W-1:0] q, input logic neg);
    sat_t             o;
    logic [CMP_W-1:0] qe, lim;
    qe    = CMP_W'(q);
    lim   = CMP_W'(1) << (OUT_WIDTH - 1);
    o.hit = 1'b0;
    if (neg) begin
      if (qe > lim) begin
        qe    = lim;
        o.hit = 1'b1;
      end
      qe = -qe;
    end else if (qe > lim - 1'b1) begin
      qe    = lim - 1'b1;
      o.hit = 1'b1;
    end
    o.v = qe[OUT_WIDTH-1:0];
    return o;
  endfunction

  function automatic logic [NMAG_W-1:0] nmag(input logic signed [NUM_W-1:0] n);
    logic [NUM_W-1:0] m;
    m = n[NUM_W-1] ? -n : n;
    return m[NMAG_W-1:0];
  endfunction

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // square root stages
  always_comb begin
    sq_nxt[0].kind  = in_data.kind;
    sq_nxt[0].b     = in_data.b;
    sq_nxt[0].a_neg = in_data.a_neg;
    sq_nxt[0].den   = in_data.den;
    sq_nxt[0].d     = DP_W'(in_data.dmag);
    sq_nxt[0].rem   = '0;
    sq_nxt[0].root  = '0;
    for (int i = 1; i <= SQ_STEPS; i++) sq_nxt[i] = sq_step(sq_r[i-1]);
  end

  // numerators, signs and divider stages
  always_comb begin
    logic signed [NUM_W-1:0] nb, sv, n1, n2;
    logic [NMAG_W-1:0]       m1, m2;
    sq_t                     s;
    s  = sq_r[SQ_STEPS];
    nb = -NUM_W'(s.b);
    sv = $signed({2'b00, s.root});
    n1 = (s.kind == KIND_REAL) ? (nb + sv) : nb;
    case (s.kind)
      KIND_REAL:    n2 = nb - sv;
      KIND_COMPLEX: n2 = sv;
      default:      n2 = nb;
    endcase
    m1 = nmag(n1);
    m2 = nmag(n2);
    dv_nxt[0].kind = s.kind;
    dv_nxt[0].den  = s.den;
    dv_nxt[0].neg1 = n1[NUM_W-1] ^ s.a_neg;
    dv_nxt[0].neg2 = (s.kind == KIND_COMPLEX) ? 1'b0 : (n2[NUM_W-1] ^ s.a_neg);
    dv_nxt[0].dq1  = DIV_W'(m1) << IN_FRAC_BITS;
    dv_nxt[0].dq2  = DIV_W'(m2) << IN_FRAC_BITS;
    dv_nxt[0].r1   = '0;
    dv_nxt[0].r2   = '0;
    for (int i = 1; i <= DIV_W; i++) begin
      dv_nxt[i] = dv_r[i-1];
      {dv_nxt[i].r1, dv_nxt[i].dq1} = div_step(dv_r[i-1].dq1, dv_r[i-1].r1, dv_r[i-1].den);
      {dv_nxt[i].r2, dv_nxt[i].dq2} = div_step(dv_r[i-1].dq2, dv_r[i-1].r2, dv_r[i-1].den);
    end
  end

  // result formatting
  always_comb begin
    sat_t f, g;
    dv_t  e;
    e = dv_r[DIV_W];
    f = clamp(e.dq1, e.neg1);
    g = clamp(e.dq2, e.neg2);
    out_nxt.root_kind = e.kind;
    if (e.kind == KIND_INVALID) begin
      out_nxt.first_value  = '0;
      out_nxt.second_value = '0;
      out_nxt.saturated    = 1'b0;
    end else begin
      out_nxt.first_value  = f.v;
      out_nxt.second_value = g.v;
      out_nxt.saturated    = f.hit | g.hit;
    end
  end

  // stage valid bits, whole pipe advances together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= SQ_STEPS; i++) sqv_r[i] <= 1'b0;
      for (int i = 0; i <= DIV_W; i++) dvv_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      sqv_r[0] <= in_valid;
      for (int i = 1; i <= SQ_STEPS; i++) sqv_r[i] <= sqv_r[i-1];
      dvv_r[0] <= sqv_r[SQ_STEPS];
      for (int i = 1; i <= DIV_W; i++) dvv_r[i] <= dvv_r[i-1];
      out_valid_r <= dvv_r[DIV_W];
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= SQ_STEPS; i++) sq_r[i] <= sq_nxt[i];
      for (int i = 0; i <= DIV_W; i++) dv_r[i] <= dv_nxt[i];
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== test/testbench.sv =====
// testbench for the quadratic root solver: streams equations and checks roots
`timescale 1ns / 100ps

module testbench;
  import qrs_pkg::*;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  out_t  expected_roots[$];
  int    error_count = 0;
  bit    long_hold = 1'b0;
  bit    stall_enable = 1'b1;

  quadratic_root_solver u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // one root: (num << frac) / den truncated toward zero, clamped to the output range
  function automatic logic signed [OUT_WIDTH-1:0] scaled_quotient(
      input logic signed [63:0] num, input logic signed [63:0] den, inout bit sat);
    logic [127:0] mag_n;
    logic [127:0] mag_d;
    logic [127:0] q;
    logic [127:0] lim;
    bit neg;
    mag_n = (num < 0) ? 128'(-num) : 128'(num);
    mag_d = (den < 0) ? 128'(-den) : 128'(den);
    q = (mag_n << IN_FRAC_BITS) / mag_d;
    neg = (num < 0) != (den < 0);
    lim = 128'(1) << (OUT_WIDTH - 1);
    if (neg) begin
      if (q > lim) begin
        q = lim;
        sat = 1'b1;
      end
      return OUT_WIDTH'(-q);
    end
    if (q > lim - 1) begin
      q = lim - 1;
      sat = 1'b1;
    end
    return OUT_WIDTH'(q);
  endfunction

  // integer square root, floor
  function automatic logic [63:0] isqrt(input logic [127:0] d);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int k = 40; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (128'(t) * 128'(t) <= d) r = t;
    end
    return r;
  endfunction

  function automatic out_t solve_roots(input in_t eq);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] c;
    logic signed [127:0] disc;
    logic [127:0] dmag;
    logic signed [63:0] s;
    out_t r;
    bit sat;
    a = eq.coef_a;
    b = eq.coef_b;
    c = eq.coef_c;
    r = '0;
    sat = 1'b0;
    if (a == 0) begin
      r.root_kind = KIND_INVALID;
      return r;
    end
    disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
    dmag = (disc < 0) ? 128'(-disc) : 128'(disc);
    s = isqrt(dmag);
    if (disc > 0) begin
      r.root_kind = KIND_REAL;
      r.first_value = scaled_quotient(-b + s, 2 * a, sat);
      r.second_value = scaled_quotient(-b - s, 2 * a, sat);
    end else if (disc < 0) begin
      r.root_kind = KIND_COMPLEX;
      r.first_value = scaled_quotient(-b, 2 * a, sat);
      r.second_value = scaled_quotient(s, (a < 0) ? -2 * a : 2 * a, sat);
    end else begin
      r.root_kind = KIND_DOUBLE;
      r.first_value = scaled_quotient(-b, 2 * a, sat);
      r.second_value = r.first_value;
    end
    r.saturated = sat;
    return r;
  endfunction

  // offer one equation, after the given gap; valid holds until transfer
  task automatic send_equation(input in_t eq, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= eq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_roots.push_back(solve_roots(eq));
  endtask

  task automatic send_burst_gap(input in_t eq);
    send_equation(eq, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0);
  endtask

  function automatic logic [IN_WIDTH-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return IN_WIDTH'($urandom);
      1: return IN_WIDTH'($signed($urandom_range(0, 8191)) - 4096);
      2: return IN_WIDTH'($signed($urandom_range(0, 255)) - 128);
      3: return {1'b1, {(IN_WIDTH-1){1'b0}}} + IN_WIDTH'($urandom_range(0, 3));
      4: return {1'b0, {(IN_WIDTH-1){1'b1}}} - IN_WIDTH'($urandom_range(0, 3));
      default: return IN_WIDTH'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk) begin
    if (long_hold) out_ready <= 1'b0;
    else if (!stall_enable) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_roots.size() == 0) begin
        $error("unexpected result transfer %h", out_data);
        error_count++;
      end else begin
        exp_r = expected_roots.pop_front();
        if (out_data.root_kind !== exp_r.root_kind) begin
          $error("root_kind expected %0d got %0d", exp_r.root_kind, out_data.root_kind);
          error_count++;
        end
        if (out_data.first_value !== exp_r.first_value) begin
          $error("first_value expected %0d got %0d", exp_r.first_value,
                 out_data.first_value);
          error_count++;
        end
        if (out_data.second_value !== exp_r.second_value) begin
          $error("second_value expected %0d got %0d", exp_r.second_value,
                 out_data.second_value);
          error_count++;
        end
        if (out_data.saturated !== exp_r.saturated) begin
          $error("saturated expected %0d got %0d", exp_r.saturated, out_data.saturated);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [IN_WIDTH-1:0] mx;
    logic [IN_WIDTH-1:0] mn;
    mx = {1'b0, {(IN_WIDTH-1){1'b1}}};
    mn = {1'b1, {(IN_WIDTH-1){1'b0}}};
    send_equation('{24'd0, 24'd4096, 24'd4096}, 0);    // zero a
    send_equation('{24'd0, mn, mx}, 0);
    send_equation('{24'd4096, 24'd0, -24'sd4096}, 0);  // two real roots
    send_equation('{24'd4096, 24'd0, 24'd4096}, 0);    // complex pair
    send_equation('{-24'sd4096, 24'd0, -24'sd4096}, 0); // complex, negative a
    send_equation('{24'd4096, 24'd8192, 24'd4096}, 0); // double root
    send_equation('{24'd4096, 24'd0, 24'd0}, 0);       // double root at zero
    send_equation('{24'd1, mx, 24'd0}, 0);             // saturating
    send_equation('{24'd1, mn, mx}, 0);
    send_equation('{mx, mx, mx}, 0);
    send_equation('{mn, mn, mn}, 0);
    send_equation('{mn, mx, mn}, 0);
    send_equation('{mx, mn, mx}, 0);
    send_equation('{24'hffffff, 24'hffffff, 24'hffffff}, 0);
    send_equation('{24'd1, 24'd0, mx}, 0);
    send_equation('{-24'sd1, 24'd0, mx}, 0);
    send_equation('{24'd1, 24'd0, 24'd1}, 0);
  endtask

  task automatic test_random_streams();
    in_t eq;
    for (int i = 0; i < 1300; i++) begin
      eq.coef_a = ($urandom_range(0, 40) == 0) ? '0 : rand_coef();
      eq.coef_b = rand_coef();
      if ($urandom_range(0, 9) == 0 && eq.coef_a != 0) begin
        // aim at a double root: b = 2k, c = k*k/a with a = 1
        eq.coef_a = IN_WIDTH'(1);
        eq.coef_b = IN_WIDTH'($signed($urandom_range(0, 4000)) - 2000) << 1;
        eq.coef_c = IN_WIDTH'(($signed(eq.coef_b) / 2) * ($signed(eq.coef_b) / 2));
      end else begin
        eq.coef_c = rand_coef();
      end
      send_burst_gap(eq);
    end
  endtask

  // receiver holds off while the sender keeps offering back-to-back, then a stall-free run
  task automatic test_backpressure();
    in_t eq;
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 120; i++) begin
        eq = {rand_coef(), rand_coef(), rand_coef()};
        send_equation(eq, 0);
      end
    join
    stall_enable = 1'b0;
    for (int i = 0; i < 30; i++) begin
      eq = {rand_coef(), rand_coef(), rand_coef()};
      send_equation(eq, 0);
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_streams();
    test_backpressure();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_fifo.sv
rtl/core/qrs_back.sv
rtl/core/quadratic_root_solver.sv
test/testbench.sv
